/* rtl/mam_pkg.sv */
// ----------------------------------------------------------------------------
// mam_pkg
// shared types and constants of the midi action matcher
// ----------------------------------------------------------------------------
package mam_pkg;

  localparam int NUM_ACTIONS = 7;   // action slots, 1 to 8
  localparam int NUM_PORTS   = 16;  // input ports, 1 to 16
  localparam int NUM_REGS    = 7;   // pattern registers in the register map

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int ACT_IDX_W   = 3;
  localparam int PORT_W      = 4;

  localparam logic [6:0] VEL_SPLIT = 7'd64;

  // message types, high nibble of the status byte
  localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
  localparam logic [3:0] MSG_POLY_AT    = 4'hA;
  localparam logic [3:0] MSG_CTRL       = 4'hB;
  localparam logic [3:0] MSG_PROG       = 4'hC;
  localparam logic [3:0] MSG_CHAN_PRESS = 4'hD;
  localparam logic [3:0] MSG_PITCH_BEND = 4'hE;

  // velocity test modes
  localparam logic [1:0] VEL_ANY   = 2'd0;
  localparam logic [1:0] VEL_HIGH  = 2'd1;
  localparam logic [1:0] VEL_LOW   = 2'd2;
  localparam logic [1:0] VEL_EXACT = 2'd3;

  typedef struct packed {
    logic [6:0] vel;
    logic [1:0] velmode;
    logic [6:0] note;
    logic       noteany;
    logic [3:0] chan;
    logic       chany;
    logic [3:0] port;
    logic       portany;
    logic       cont;
    logic [3:0] ptype;
  } pattern_t;

  typedef pattern_t [NUM_ACTIONS-1:0] pattern_arr_t;

  // one classified message waiting for the back end
  typedef struct packed {
    logic [NUM_ACTIONS-1:0] mask;
    logic [6:0]             d1;
    logic [6:0]             d2;
  } q_entry_t;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/mam_front.sv */
// ----------------------------------------------------------------------------
// mam_front
// classifies a message against all action patterns in parallel
// ----------------------------------------------------------------------------
module mam_front import mam_pkg::*; (
  input  logic               in_valid_i,
  input  logic [PORT_W-1:0]  in_port_i,
  input  logic [7:0]         status_byte_i,
  input  logic [6:0]         data_first_i,
  input  logic [6:0]         data_second_i,
  input  pattern_arr_t       patterns_i,
  input  q_status_t          q_status_i,
  output logic               in_stall_o,
  output logic               push_o,
  output q_entry_t           entry_o
);

  function automatic logic pat_match(input pattern_t p, input logic [3:0] port,
                                     input logic [3:0] stype, input logic [3:0] chan,
                                     input logic [6:0] d1, input logic [6:0] d2);
    logic       ok;
    logic [6:0] tested;
    ok = (p.ptype >= MSG_NOTE_OFF) && (p.ptype <= MSG_PITCH_BEND);
    if (!p.portany && (p.port != port)) ok = 1'b0;
    if (!p.chany && (p.chan != chan)) ok = 1'b0;
    case (p.ptype)
      MSG_NOTE_OFF: begin
        if (!((stype == MSG_NOTE_OFF) || ((stype == MSG_NOTE_ON) && (d2 == 7'd0))))
          ok = 1'b0;
      end
      MSG_NOTE_ON: begin
        if (!((stype == MSG_NOTE_ON) && (d2 != 7'd0))) ok = 1'b0;
      end
      default: begin
        if (stype != p.ptype) ok = 1'b0;
      end
    endcase
    if ((p.ptype < MSG_CHAN_PRESS) && !p.noteany && (p.note != d1)) ok = 1'b0;
    tested = (p.ptype == MSG_CHAN_PRESS) ? d1 : d2;
    if ((p.ptype != MSG_PROG) && !p.cont) begin
      case (p.velmode)
        VEL_HIGH:  if (tested < VEL_SPLIT) ok = 1'b0;
        VEL_LOW:   if (tested >= VEL_SPLIT) ok = 1'b0;
        VEL_EXACT: if (tested != p.vel) ok = 1'b0;
        default:   ;
      endcase
    end
    return ok;
  endfunction

  logic [3:0] stype;
  logic       msg_ok;

  assign stype  = status_byte_i[7:4];
  assign msg_ok = ({1'b0, in_port_i} < (PORT_W+1)'(NUM_PORTS)) &&
                  (stype >= MSG_NOTE_OFF) && (stype <= MSG_PITCH_BEND);

  always_comb begin
    entry_o.d1 = data_first_i;
    entry_o.d2 = data_second_i;
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      entry_o.mask[i] = msg_ok && pat_match(patterns_i[i], in_port_i, stype,
                                            status_byte_i[3:0], data_first_i,
                                            data_second_i);
    end
  end

  // messages without any match are taken and dropped here
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full && (entry_o.mask != '0);

endmodule

/* rtl/mam_queue.sv */
// ----------------------------------------------------------------------------
// mam_queue
// two-entry queue between the front and back end
// ----------------------------------------------------------------------------
module mam_queue import mam_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_entry_t  entry_i,
  input  logic      pop_i,
  output q_entry_t  entry_o,
  output q_status_t status_o
);

  q_entry_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  logic do_push, do_pop;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign entry_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

/* rtl/mam_back.sv */
// ----------------------------------------------------------------------------
// mam_back
// walks a message's match mask, emits one result per cycle unless stalled
// ----------------------------------------------------------------------------
module mam_back import mam_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pattern_arr_t         patterns_i,
  input  q_status_t            q_status_i,
  input  q_entry_t             q_entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ACT_IDX_W-1:0] action_index_o,
  output logic                 has_value_o,
  output logic [6:0]           value_o,
  output logic                 last_o
);

  logic                   cur_valid_q, cur_valid_d;
  logic [NUM_ACTIONS-1:0] rem_q, rem_d;
  logic [6:0]             d1_q, d1_d, d2_q, d2_d;

  logic                   out_valid_q, out_valid_d;
  logic [ACT_IDX_W-1:0]   idx_q, idx_d;
  logic                   hasv_q, hasv_d;
  logic [6:0]             val_q, val_d;
  logic                   last_q, last_d;

  logic [NUM_ACTIONS-1:0] sel_oh, rest;
  logic [ACT_IDX_W-1:0]   sel_idx;
  logic                   sel_hasv;
  logic [6:0]             sel_val;
  logic                   emit, load;

  always_comb begin
    sel_oh   = rem_q & (~rem_q + NUM_ACTIONS'(1));
    rest     = rem_q & ~sel_oh;
    sel_idx  = '0;
    sel_hasv = 1'b0;
    sel_val  = '0;
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      if (sel_oh[i]) begin
        sel_idx = ACT_IDX_W'(i);
        if (patterns_i[i].ptype == MSG_PROG) begin
          sel_hasv = 1'b0;
          sel_val  = '0;
        end else begin
          sel_hasv = 1'b1;
          sel_val  = (patterns_i[i].ptype == MSG_CHAN_PRESS) ? d1_q : d2_q;
        end
      end
    end

    emit = cur_valid_q && (!out_valid_q || !out_stall_i);
    load = !q_status_i.empty && (!cur_valid_q || (emit && (rest == '0)));

    cur_valid_d = cur_valid_q;
    rem_d       = rem_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    if (emit) begin
      rem_d = rest;
      if (rest == '0) cur_valid_d = 1'b0;
    end
    if (load) begin
      cur_valid_d = 1'b1;
      rem_d       = q_entry_i.mask;
      d1_d        = q_entry_i.d1;
      d2_d        = q_entry_i.d2;
    end

    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    hasv_d      = hasv_q;
    val_d       = val_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      idx_d       = sel_idx;
      hasv_d      = sel_hasv;
      val_d       = sel_val;
      last_d      = (rest == '0);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q   <= d1_d;
    d2_q   <= d2_d;
    idx_q  <= idx_d;
    hasv_q <= hasv_d;
    val_q  <= val_d;
    last_q <= last_d;
  end

  assign pop_o          = load;
  assign out_valid_o    = out_valid_q;
  assign action_index_o = idx_q;
  assign has_value_o    = hasv_q;
  assign value_o        = val_q;
  assign last_o         = last_q;

endmodule

/* rtl/midi_action_matcher_unit.sv */
// ----------------------------------------------------------------------------
// midi_action_matcher_unit
// matches midi channel messages against seven action patterns
// ----------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  in       input      in_valid_i / in_stall_o  in_port, status_byte, data bytes
//  out      output     out_valid_o / out_stall_i action_index, has_value, value, last
//  cfg      input      cfg_we_i                 cfg_index_i, cfg_data_i
//
//  a message is classified in the cycle it is accepted and can be followed
//  by another in the next cycle while the two-entry queue has room
//  a message with k matches gives k words, one word per cycle through the
//  output register unless out_stall_i holds it; messages with no match are
//  taken at the input and leave nothing behind
//  reset clears the pattern registers, the queue and all valid flags
//  out_stall_i holds the output register; once the queue fills the input
//  is stalled, so each side stalls on its own
// ----------------------------------------------------------------------------
module midi_action_matcher_unit import mam_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // message channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PORT_W-1:0]     in_port_i,
  input  logic [7:0]            status_byte_i,
  input  logic [6:0]            data_first_i,
  input  logic [6:0]            data_second_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ACT_IDX_W-1:0]  action_index_o,
  output logic                  has_value_o,
  output logic [6:0]            value_o,
  output logic                  last_o
);

  // pattern registers; slots past the register map stay zero and never match
  pattern_arr_t patterns_q, patterns_d;

  always_comb begin
    patterns_d = patterns_q;
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      if (cfg_we_i && (i < NUM_REGS) &&
          ({1'b0, cfg_index_i} == (CFG_IDX_W+1)'(i))) begin
        patterns_d[i] = pattern_t'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      patterns_q <= '0;
    end else begin
      patterns_q <= patterns_d;
    end
  end

  // front end to queue
  q_status_t q_status;
  q_entry_t  push_entry, head_entry;
  logic      push, pop;

  mam_front u_front (
    .in_valid_i    (in_valid_i),
    .in_port_i     (in_port_i),
    .status_byte_i (status_byte_i),
    .data_first_i  (data_first_i),
    .data_second_i (data_second_i),
    .patterns_i    (patterns_q),
    .q_status_i    (q_status),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  mam_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (q_status)
  );

  // back end walks matches in action order
  mam_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .patterns_i     (patterns_q),
    .q_status_i     (q_status),
    .q_entry_i      (head_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_index_o (action_index_o),
    .has_value_o    (has_value_o),
    .value_o        (value_o),
    .last_o         (last_o)
  );

endmodule

/* tb/midi_action_matcher_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_action_matcher_checker
// watches the config port and both word channels, predicts the result words
// of every accepted message and compares them in order with what comes out
// ----------------------------------------------------------------------------
module midi_action_matcher_checker import mam_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [PORT_W-1:0]     in_port_i,
  input  logic [7:0]            status_byte_i,
  input  logic [6:0]            data_first_i,
  input  logic [6:0]            data_second_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [ACT_IDX_W-1:0]  action_index_i,
  input  logic                  has_value_i,
  input  logic [6:0]            value_i,
  input  logic                  last_i,
  output int                    mismatch_count_o,
  output int                    words_pending_o
);

  typedef struct packed {
    logic [ACT_IDX_W-1:0] action;
    logic                 has_value;
    logic [6:0]           value;
    logic                 last;
  } result_word_t;

  pattern_t     slot_pattern [NUM_ACTIONS];
  result_word_t expected_words [$];
  int           fail_count = 0;

  assign mismatch_count_o = fail_count;

  function automatic bit pattern_hits(input pattern_t p, input logic [3:0] port,
                                      input logic [3:0] mtype, input logic [3:0] chan,
                                      input logic [6:0] d1, input logic [6:0] d2);
    logic [6:0] probe;
    bit         type_ok;
    if (p.ptype < MSG_NOTE_OFF || p.ptype > MSG_PITCH_BEND) return 1'b0;
    if (!p.portany && p.port != port) return 1'b0;
    if (!p.chany && p.chan != chan) return 1'b0;
    case (p.ptype)
      // note-on with zero velocity counts as a note-off
      MSG_NOTE_OFF: type_ok = (mtype == MSG_NOTE_OFF) || (mtype == MSG_NOTE_ON && d2 == 7'd0);
      MSG_NOTE_ON:  type_ok = (mtype == MSG_NOTE_ON) && (d2 != 7'd0);
      default:      type_ok = (mtype == p.ptype);
    endcase
    if (!type_ok) return 1'b0;
    if (p.ptype < MSG_CHAN_PRESS && !p.noteany && p.note != d1) return 1'b0;
    if (p.ptype != MSG_PROG && !p.cont) begin
      probe = (p.ptype == MSG_CHAN_PRESS) ? d1 : d2;
      case (p.velmode)
        VEL_HIGH:  if (probe < VEL_SPLIT) return 1'b0;
        VEL_LOW:   if (probe >= VEL_SPLIT) return 1'b0;
        VEL_EXACT: if (probe != p.vel) return 1'b0;
        default: ;
      endcase
    end
    return 1'b1;
  endfunction

  // queues one word per matching slot, last flag on the final one
  task automatic predict_message(input logic [3:0] port, input logic [7:0] status,
                                 input logic [6:0] d1, input logic [6:0] d2);
    result_word_t held;
    bit           have;
    have = 1'b0;
    held = '0;
    if (status[7:4] < MSG_NOTE_OFF || status[7:4] > MSG_PITCH_BEND) return;
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      if (pattern_hits(slot_pattern[i], port, status[7:4], status[3:0], d1, d2)) begin
        if (have) expected_words = {expected_words, held};
        held.action    = i[ACT_IDX_W-1:0];
        held.has_value = (slot_pattern[i].ptype != MSG_PROG);
        held.value     = !held.has_value ? 7'd0 :
                         (slot_pattern[i].ptype == MSG_CHAN_PRESS) ? d1 : d2;
        held.last      = 1'b0;
        have           = 1'b1;
      end
    end
    if (have) begin
      held.last = 1'b1;
      expected_words = {expected_words, held};
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ACTIONS; i++) slot_pattern[i] = '0;
      expected_words.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected, action %0d",
                                    action_index_i));
        end else begin
          want = expected_words.pop_front();
          if (action_index_i !== want.action)
            report_mismatch($sformatf("action_index %0d, expected %0d",
                                      action_index_i, want.action));
          if (has_value_i !== want.has_value)
            report_mismatch($sformatf("has_value %0b, expected %0b action %0d",
                                      has_value_i, want.has_value, want.action));
          if (value_i !== want.value)
            report_mismatch($sformatf("value %0d, expected %0d action %0d",
                                      value_i, want.value, want.action));
          if (last_i !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b action %0d",
                                      last_i, want.last, want.action));
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_message(in_port_i, status_byte_i, data_first_i, data_second_i);
      if (cfg_we_i && cfg_index_i < NUM_REGS && cfg_index_i < NUM_ACTIONS)
        slot_pattern[cfg_index_i] = pattern_t'(cfg_data_i);
    end
    words_pending_o = expected_words.size();
  end

endmodule

/* tb/tb_midi_action_matcher_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_action_matcher_unit
// drives midi messages and pattern writes into the matcher; a checker beside
// the block predicts every result word and counts mismatches
// ----------------------------------------------------------------------------
module tb_midi_action_matcher_unit;
  import mam_pkg::*;

  // register map of the pattern registers, the spare index is not mapped
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALUE, REG_ON, REG_OFF, REG_TOGGLE, REG_TRIGGER, REG_GOTO_LOW, REG_GOTO_HIGH,
    REG_SPARE
  } reg_idx_e;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 12;    // back end latency margin before a reconfig
  localparam int HOLD_CYCLES  = 100;   // long receiver hold-off

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [PORT_W-1:0]     in_port_i;
  logic [7:0]            status_byte_i;
  logic [6:0]            data_first_i;
  logic [6:0]            data_second_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [ACT_IDX_W-1:0]  action_index_o;
  logic                  has_value_o;
  logic [6:0]            value_o;
  logic                  last_o;

  int mismatch_count;
  int words_pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  // copy of the loaded patterns, only used to aim messages at them
  pattern_t cur_pat [NUM_REGS] = '{default: '0};

  always #5 clk_i = ~clk_i;

  midi_action_matcher_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_port_i      (in_port_i),
    .status_byte_i  (status_byte_i),
    .data_first_i   (data_first_i),
    .data_second_i  (data_second_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_index_o (action_index_o),
    .has_value_o    (has_value_o),
    .value_o        (value_o),
    .last_o         (last_o)
  );

  midi_action_matcher_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_port_i        (in_port_i),
    .status_byte_i    (status_byte_i),
    .data_first_i     (data_first_i),
    .data_second_i    (data_second_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_index_i   (action_index_o),
    .has_value_i      (has_value_o),
    .value_i          (value_o),
    .last_i           (last_o),
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending)
  );

  // receiver: a counted hold-off wins over the random stall
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles where nothing at all is accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb_midi_action_matcher_unit failed");
          $finish;
        end
      end
    end
  end

  function automatic pattern_t pack_pattern(input logic [3:0] ptype, input bit cont,
                                            input bit portany, input logic [3:0] port,
                                            input bit chany, input logic [3:0] chan,
                                            input bit noteany, input logic [6:0] note,
                                            input logic [1:0] velmode,
                                            input logic [6:0] vel);
    pattern_t p;
    p.ptype   = ptype;
    p.cont    = cont;
    p.portany = portany;
    p.port    = port;
    p.chany   = chany;
    p.chan    = chan;
    p.noteany = noteany;
    p.note    = note;
    p.velmode = velmode;
    p.vel     = vel;
    return p;
  endfunction

  // mostly valid types with plenty of wildcards, now and then an extreme word
  function automatic pattern_t random_pattern();
    pattern_t p;
    p = pattern_t'($urandom());
    case ($urandom_range(9))
      0: p = '0;
      1: p = '1;
      2: ;  // raw word, usually an unused type code
      default: begin
        p.ptype = 4'($urandom_range(MSG_NOTE_OFF, MSG_PITCH_BEND));
        if ($urandom_range(3) != 0) p.portany = 1'b1;
        if ($urandom_range(3) != 0) p.chany   = 1'b1;
        if ($urandom_range(1) != 0) p.noteany = 1'b1;
      end
    endcase
    return p;
  endfunction

  // pattern write, one cycle of write enable
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    if (idx < NUM_REGS) cur_pat[idx] = pattern_t'(data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // offer one message word and hold it until the block takes it
  task automatic send_msg(input logic [3:0] port, input logic [7:0] status,
                          input logic [6:0] d1, input logic [6:0] d2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    in_port_i     = port;
    status_byte_i = status;
    data_first_i  = d1;
    data_second_i = d2;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // a message built to hit one of the loaded patterns, sometimes broken
  task automatic send_aimed();
    pattern_t   p;
    logic [3:0] port, chan, mtype;
    logic [6:0] d1, d2, probe;
    p     = cur_pat[$urandom_range(NUM_REGS - 1)];
    port  = p.portany ? 4'($urandom()) : p.port;
    chan  = p.chany ? 4'($urandom()) : p.chan;
    mtype = (p.ptype >= MSG_NOTE_OFF && p.ptype <= MSG_PITCH_BEND) ?
            p.ptype : 4'($urandom_range(MSG_NOTE_OFF, MSG_PITCH_BEND));
    d1    = p.noteany ? 7'($urandom()) : p.note;
    case (p.velmode)
      VEL_HIGH:  probe = 7'($urandom_range(64, 127));
      VEL_LOW:   probe = 7'($urandom_range(0, 63));
      VEL_EXACT: probe = ($urandom_range(3) != 0) ? p.vel : 7'($urandom());
      default:   probe = 7'($urandom());
    endcase
    if (mtype == MSG_CHAN_PRESS) begin
      d1 = probe;
      d2 = 7'($urandom());
    end else begin
      d2 = probe;
    end
    // note-off also comes as note-on with zero velocity
    if (mtype == MSG_NOTE_OFF && $urandom_range(1) != 0) begin
      mtype = MSG_NOTE_ON;
      d2    = 7'd0;
    end
    if ($urandom_range(7) == 0) d1 = 7'($urandom());
    send_msg(port, {mtype, chan}, d1, d2);
  endtask

  // drop valid and wait until every predicted word is out, plus margin
  task automatic settle();
    in_valid_i = 1'b0;
    @(negedge clk_i);
    while (words_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    in_valid_i    = 1'b0;
    in_port_i     = '0;
    status_byte_i = '0;
    data_first_i  = '0;
    data_second_i = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_VALUE;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed patterns: one of each message type, each velocity mode
    write_reg(REG_VALUE,     pack_pattern(MSG_CTRL, 1, 1, 0, 0, 0, 0, 7, VEL_EXACT, 5));
    write_reg(REG_ON,        pack_pattern(MSG_NOTE_ON, 0, 0, 3, 1, 0, 0, 60, VEL_HIGH, 0));
    write_reg(REG_OFF,       pack_pattern(MSG_NOTE_OFF, 0, 1, 0, 1, 0, 0, 60, VEL_ANY, 0));
    write_reg(REG_TOGGLE,    pack_pattern(MSG_PROG, 0, 1, 0, 0, 2, 0, 5, VEL_EXACT, 9));
    write_reg(REG_TRIGGER,   pack_pattern(MSG_CHAN_PRESS, 0, 1, 0, 1, 0, 0, 33, VEL_EXACT,
                                          100));
    write_reg(REG_GOTO_LOW,  pack_pattern(MSG_PITCH_BEND, 0, 1, 0, 1, 0, 1, 0, VEL_LOW, 0));
    write_reg(REG_GOTO_HIGH, pack_pattern(MSG_POLY_AT, 0, 1, 0, 1, 0, 1, 0, VEL_EXACT, 127));
    // unmapped index, must leave every pattern as it is
    write_reg(REG_SPARE, '1);

    send_msg(4'd3,  {MSG_NOTE_ON, 4'd0},    7'd60,  7'd100);  // on
    send_msg(4'd3,  {MSG_NOTE_ON, 4'd0},    7'd60,  7'd64);   // on at the split
    send_msg(4'd3,  {MSG_NOTE_ON, 4'd0},    7'd60,  7'd63);   // below the split
    send_msg(4'd3,  {MSG_NOTE_ON, 4'd5},    7'd60,  7'd0);    // zero velocity note-on
    send_msg(4'd0,  {MSG_NOTE_OFF, 4'd15},  7'd60,  7'd127);  // plain note-off
    send_msg(4'd2,  {MSG_NOTE_ON, 4'd0},    7'd60,  7'd100);  // wrong port
    send_msg(4'd15, {MSG_CTRL, 4'd0},       7'd7,   7'd0);    // continuous, velocity ignored
    send_msg(4'd15, {MSG_CTRL, 4'd0},       7'd7,   7'd127);
    send_msg(4'd0,  {MSG_CTRL, 4'd1},       7'd7,   7'd50);   // wrong channel
    send_msg(4'd0,  {MSG_PROG, 4'd2},       7'd5,   7'd0);    // program change, no value
    send_msg(4'd0,  {MSG_PROG, 4'd2},       7'd6,   7'd0);    // wrong program
    send_msg(4'd7,  {MSG_CHAN_PRESS, 4'd9}, 7'd100, 7'd0);    // pressure tests data_first
    send_msg(4'd7,  {MSG_CHAN_PRESS, 4'd9}, 7'd99,  7'd100);
    send_msg(4'd1,  {MSG_PITCH_BEND, 4'd3}, 7'd0,   7'd0);    // low bend
    send_msg(4'd1,  {MSG_PITCH_BEND, 4'd3}, 7'd127, 7'd64);
    send_msg(4'd4,  {MSG_POLY_AT, 4'd0},    7'd127, 7'd127);  // exact top velocity
    send_msg(4'd4,  8'h7F,                  7'd127, 7'd127);  // data byte as status
    send_msg(4'd4,  8'hF0,                  7'd60,  7'd100);  // system message
    send_msg(4'd15, 8'hFF,                  7'd127, 7'd127);
    send_msg(4'd0,  8'h00,                  7'd0,   7'd0);
    settle();

    // every slot catches any controller, so each word fans out to seven
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(reg_idx_e'(i), pack_pattern(MSG_CTRL, 0, 1, 0, 1, 0, 1, 0, VEL_ANY, 0));
    // long hold-off on the result side while messages keep coming
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    @(negedge clk_i);
    repeat (12) send_msg(4'($urandom()), {MSG_CTRL, 4'($urandom())}, 7'($urandom()),
                         7'($urandom()));
    settle();

    // random phases: idle mix changes every two phases
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin send_idle_pct = 21; recv_idle_pct = 47; end
        1: begin send_idle_pct = 47; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int i = 0; i < NUM_REGS; i++) write_reg(reg_idx_e'(i), random_pattern());
      repeat (30) begin
        if ($urandom_range(3) != 0) send_aimed();
        else send_msg(4'($urandom()), 8'($urandom()), 7'($urandom()), 7'($urandom()));
      end
      settle();
    end

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("tb_midi_action_matcher_unit passed");
    end else begin
      $display("tb_midi_action_matcher_unit failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mam_pkg.sv
rtl/mam_front.sv
rtl/mam_queue.sv
rtl/mam_back.sv
rtl/midi_action_matcher_unit.sv
tb/midi_action_matcher_checker.sv
tb/tb_midi_action_matcher_unit.sv
